### hdl/sfcca_pkg.sv
// ----------------------------------------------------------------------------
// sfcca_pkg
// Shared types, codes and helpers for the sensor frame check, convert and
// accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcca_pkg;

  // result codes reported with every item
  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_BUS     = 3'd1,
    RC_TIMEOUT = 3'd2,
    RC_STATUS  = 3'd3,
    RC_ZERO    = 3'd4,
    RC_CRC     = 3'd5,
    RC_RANGE   = 3'd6
  } result_code_t;

  // bus outcome codes
  localparam logic [1:0] BUS_FRAME   = 2'd0;
  localparam logic [1:0] BUS_TIMEOUT = 2'd2;

  // status byte bits
  localparam int STATUS_BUSY_BIT = 7;
  localparam int STATUS_CAL_BIT  = 3;

  // crc-8 settings
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // conversion scale factors, divisor is 2^20 (a plain shift)
  localparam int          RAW_W      = 20;
  localparam logic [13:0] HUM_SCALE  = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;
  localparam logic [13:0] HUM_MAX    = 14'd10000;
  // temperature limits -4000..8500 seen before the offset is taken off
  localparam logic [14:0] TEMP_RAW_MIN = 15'd1000;
  localparam logic [14:0] TEMP_RAW_MAX = 15'd13500;

  // queue between the classifier and the accumulator
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // failure cause counters
  localparam int CAUSE_COUNT = 5;
  localparam int CAUSE_IDX_W = $clog2(CAUSE_COUNT);

  // one classified item handed from front to back
  typedef struct packed {
    logic               clear_sums;
    result_code_t       code;
    logic [13:0]        humidity;
    logic signed [14:0] temperature;
  } item_t;

  // crc-8, msb first, no reflection, no final xor, over six bytes
  function automatic logic [7:0] crc8_frame(input logic [47:0] frame);
    logic [7:0] crc;
    crc = CRC_INIT;
    for (int i = 5; i >= 0; i--) begin
      crc = crc ^ frame[i*8 +: 8];
      for (int k = 0; k < 8; k++) begin
        crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

### hdl/sfcca_ifs.sv
// ----------------------------------------------------------------------------
// sfcca channel interfaces
// Valid/ready channels for the raw sensor frames and the result reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcca_frame_if;
  logic       valid;
  logic       ready;
  logic       clear_sums;
  logic [1:0] bus_outcome;
  logic [7:0] status_byte;
  logic [7:0] frame_byte1;
  logic [7:0] frame_byte2;
  logic [7:0] frame_byte3;
  logic [7:0] frame_byte4;
  logic [7:0] frame_byte5;
  logic [7:0] check_byte;

  modport source (
    output valid, clear_sums, bus_outcome, status_byte, frame_byte1, frame_byte2,
           frame_byte3, frame_byte4, frame_byte5, check_byte,
    input  ready
  );
  modport sink (
    input  valid, clear_sums, bus_outcome, status_byte, frame_byte1, frame_byte2,
           frame_byte3, frame_byte4, frame_byte5, check_byte,
    output ready
  );
endinterface

interface sfcca_report_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_code;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [31:0]        good_count;
  logic signed [31:0] temperature_total;
  logic [31:0]        humidity_total;
  logic [31:0]        failure_total;
  logic [31:0]        cause_total;
  logic [31:0]        sequence_number;

  modport source (
    output valid, result_code, temperature_centi, humidity_centi, good_count,
           temperature_total, humidity_total, failure_total, cause_total,
           sequence_number,
    input  ready
  );
  modport sink (
    input  valid, result_code, temperature_centi, humidity_centi, good_count,
           temperature_total, humidity_total, failure_total, cause_total,
           sequence_number,
    output ready
  );
endinterface

`default_nettype wire

### hdl/sensor_frame_check_convert_accumulate_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_check_convert_accumulate_unit
// Checks humidity/temperature sensor frames, converts good ones to hundredths
// and keeps running sample, sum and failure statistics.
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  sensor   in   sink     clear flag, bus outcome, status and five frame bytes, crc byte
//  report   out  source   result code, last values, sums, counters
//
//  one item per cycle while reports are taken; a frame's report is valid once
//  it has passed the queue, then the output register
//  crc, status checks and both scaling multiplies sit in the front stage
//  reset clears all counters, sums, last values and the queue
//  a stalled report stops the back stage; the front keeps taking items until
//  the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_check_convert_accumulate_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  sfcca_frame_if.sink     sensor,
  sfcca_report_if.source  report
);
  import sfcca_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  queue_full;
  logic  pop_valid;

  sfcca_front u_front (
    .sensor     (sensor),
    .queue_full (queue_full),
    .push_item  (push_item),
    .push       (push)
  );

  sfcca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  sfcca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .report    (report)
  );

endmodule

`default_nettype wire

### hdl/sfcca_front.sv
// ----------------------------------------------------------------------------
// sfcca_front
// Accepts raw frames, checks bus outcome, status, payload, crc and range,
// converts the raw values to hundredths and pushes one classified item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcca_front (
  sfcca_frame_if.sink    sensor,
  input  wire logic      queue_full,
  output sfcca_pkg::item_t push_item,
  output logic           push
);
  import sfcca_pkg::*;

  logic [RAW_W-1:0] raw_hum;
  logic [RAW_W-1:0] raw_temp;
  logic [33:0]      hum_prod;
  logic [34:0]      temp_prod;
  logic [13:0]      hum_val;
  logic [14:0]      temp_raw_centi;
  logic             status_bad;
  logic             payload_zero;
  logic             crc_bad;
  logic             range_bad;
  result_code_t     code;

  assign sensor.ready = !queue_full;
  assign push         = sensor.valid && !queue_full;

  assign raw_hum  = {sensor.frame_byte1, sensor.frame_byte2, sensor.frame_byte3[7:4]};
  assign raw_temp = {sensor.frame_byte3[3:0], sensor.frame_byte4, sensor.frame_byte5};

  // scale then drop the 2^20 divisor
  assign hum_prod       = 34'(raw_hum) * 34'(HUM_SCALE);
  assign temp_prod      = 35'(raw_temp) * 35'(TEMP_SCALE);
  assign hum_val        = hum_prod[33:20];
  assign temp_raw_centi = temp_prod[34:20];

  assign status_bad   = sensor.status_byte[STATUS_BUSY_BIT] ||
                        !sensor.status_byte[STATUS_CAL_BIT];
  assign payload_zero = (sensor.frame_byte1 | sensor.frame_byte2 | sensor.frame_byte3 |
                         sensor.frame_byte4 | sensor.frame_byte5) == 8'd0;
  assign crc_bad      = crc8_frame({sensor.status_byte, sensor.frame_byte1,
                                    sensor.frame_byte2, sensor.frame_byte3,
                                    sensor.frame_byte4, sensor.frame_byte5})
                        != sensor.check_byte;
  assign range_bad    = (hum_val > HUM_MAX) || (temp_raw_centi < TEMP_RAW_MIN) ||
                        (temp_raw_centi > TEMP_RAW_MAX);

  always_comb begin
    if (sensor.bus_outcome == BUS_TIMEOUT) begin
      code = RC_TIMEOUT;
    end else if (sensor.bus_outcome != BUS_FRAME) begin
      code = RC_BUS;
    end else if (status_bad) begin
      code = RC_STATUS;
    end else if (payload_zero) begin
      code = RC_ZERO;
    end else if (crc_bad) begin
      code = RC_CRC;
    end else if (range_bad) begin
      code = RC_RANGE;
    end else begin
      code = RC_OK;
    end
  end

  always_comb begin
    push_item.clear_sums  = sensor.clear_sums;
    push_item.code        = code;
    push_item.humidity    = hum_val;
    push_item.temperature = signed'(temp_raw_centi - TEMP_OFFSET);
  end

endmodule

`default_nettype wire

### hdl/sfcca_queue.sv
// ----------------------------------------------------------------------------
// sfcca_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcca_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sfcca_pkg::item_t  push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output sfcca_pkg::item_t       pop_item
);
  import sfcca_pkg::*;

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

### hdl/sfcca_back.sv
// ----------------------------------------------------------------------------
// sfcca_back
// Takes classified items from the queue, updates counters and sums and
// holds one report in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcca_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  input  wire sfcca_pkg::item_t  pop_item,
  output logic                   pop,
  sfcca_report_if.source         report
);
  import sfcca_pkg::*;

  logic [31:0]        good_samples;
  logic [31:0]        temp_accumulator;
  logic [31:0]        hum_accumulator;
  logic signed [14:0] last_temperature;
  logic [13:0]        last_humidity;
  logic [31:0]        failures;
  logic [31:0]        seq_count;
  logic [31:0]        cause_counters [CAUSE_COUNT];

  logic [31:0]        good_samples_next;
  logic [31:0]        temp_accumulator_next;
  logic [31:0]        hum_accumulator_next;
  logic signed [14:0] last_temperature_next;
  logic [13:0]        last_humidity_next;
  logic [31:0]        failures_next;
  logic [31:0]        seq_count_next;
  logic [31:0]        cause_value;
  logic               cause_hit;
  logic [CAUSE_IDX_W-1:0] cause_idx;

  logic               out_valid;
  logic               is_ok;

  assign pop          = pop_valid && (!out_valid || report.ready);
  assign report.valid = out_valid;
  assign is_ok        = pop_item.code == RC_OK;

  // cause slots: bus, status, zero, crc, range
  always_comb begin
    cause_hit = 1'b1;
    cause_idx = '0;
    unique case (pop_item.code)
      RC_BUS:    cause_idx = CAUSE_IDX_W'(0);
      RC_STATUS: cause_idx = CAUSE_IDX_W'(1);
      RC_ZERO:   cause_idx = CAUSE_IDX_W'(2);
      RC_CRC:    cause_idx = CAUSE_IDX_W'(3);
      RC_RANGE:  cause_idx = CAUSE_IDX_W'(4);
      default:   cause_hit = 1'b0;
    endcase
  end

  always_comb begin
    // a clear applies before this item, good or not
    good_samples_next     = pop_item.clear_sums ? '0 : good_samples;
    temp_accumulator_next = pop_item.clear_sums ? '0 : temp_accumulator;
    hum_accumulator_next  = pop_item.clear_sums ? '0 : hum_accumulator;
    last_temperature_next = last_temperature;
    last_humidity_next    = last_humidity;
    seq_count_next        = seq_count;
    failures_next         = failures;
    cause_value           = '0;
    if (is_ok) begin
      good_samples_next     = good_samples_next + 32'd1;
      temp_accumulator_next = temp_accumulator_next + 32'(pop_item.temperature);
      hum_accumulator_next  = hum_accumulator_next + 32'(pop_item.humidity);
      last_temperature_next = pop_item.temperature;
      last_humidity_next    = pop_item.humidity;
      seq_count_next        = seq_count + 32'd1;
    end else begin
      failures_next = failures + 32'd1;
      if (cause_hit) begin
        cause_value = cause_counters[cause_idx] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_samples     <= '0;
      temp_accumulator <= '0;
      hum_accumulator  <= '0;
      last_temperature <= '0;
      last_humidity    <= '0;
      failures         <= '0;
      seq_count        <= '0;
      for (int i = 0; i < CAUSE_COUNT; i++) begin
        cause_counters[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        good_samples     <= good_samples_next;
        temp_accumulator <= temp_accumulator_next;
        hum_accumulator  <= hum_accumulator_next;
        last_temperature <= last_temperature_next;
        last_humidity    <= last_humidity_next;
        failures         <= failures_next;
        seq_count        <= seq_count_next;
        if (cause_hit) begin
          cause_counters[cause_idx] <= cause_value;
        end
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      report.result_code       <= pop_item.code;
      report.temperature_centi <= last_temperature_next;
      report.humidity_centi    <= last_humidity_next;
      report.good_count        <= good_samples_next;
      report.temperature_total <= signed'(temp_accumulator_next);
      report.humidity_total    <= hum_accumulator_next;
      report.failure_total     <= failures_next;
      report.cause_total       <= cause_value;
      report.sequence_number   <= seq_count_next;
    end
  end

`ifndef SYNTHESIS
  a_ok_no_cause: assert property (@(posedge clk) disable iff (rst)
    (!rst && pop && (is_ok || pop_item.code == RC_TIMEOUT)) |=> report.cause_total == 32'd0)
    else $error("cause total not zero for ok or timeout");
  a_seq_shown: assert property (@(posedge clk) disable iff (rst)
    (!rst && pop) |=> report.sequence_number == seq_count)
    else $error("reported sequence differs from counter");
  a_fail_count: assert property (@(posedge clk) disable iff (rst)
    (!rst && pop && !is_ok) |=> failures == $past(failures) + 32'd1)
    else $error("failure count not advanced");
`endif

endmodule

`default_nettype wire
